// ===== rtl/core/dshl_pkg.sv =====
// ----------------------------------------------------------------------------
// dshl_pkg
// Shared types, constants and the protocol ratio table for the history log.
// ----------------------------------------------------------------------------
package dshl_pkg;

  localparam int unsigned HistoryDepthDefault = 30;
  localparam logic [31:0] MinCodeReset       = 32'd1000;
  localparam logic [15:0] DefaultRepeatReset = 16'd10;
  localparam int unsigned CfgIdxW            = 1;
  localparam int unsigned CfgDataW           = 32;

  localparam logic [CfgIdxW-1:0] CfgMinCode       = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgDefaultRepeat = 1'b1;

  typedef enum logic [1:0] {
    OpCode  = 2'd0,
    OpSync  = 2'd1,
    OpQuery = 2'd2,
    OpNone  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    KindRecord = 2'd0,
    KindEntry  = 2'd1,
    KindStatus = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    StSynced    = 2'd0,
    StBadTime   = 2'd1,
    StNoHistory = 2'd2,
    StCount     = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    SIdle,
    SSearch,
    SStore,
    SRebase,
    SReadReq,
    SReadWait,
    SOut
  } state_e;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] code;
    logic [6:0]  bit_length;
    logic [15:0] pulse_length;
    logic [7:0]  protocol_id;
    logic        link_connected;
    logic [31:0] now_ms;
    logic [63:0] sync_time;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  status;
    logic [31:0] code_out;
    logic [6:0]  bits_out;
    logic [15:0] pulse_out;
    logic [47:0] timing_ratios;
    logic        inverted;
    logic [15:0] repeat_out;
    logic [63:0] timestamp;
    logic [4:0]  entry_count;
    logic        last;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic load;       // capture the input item
    logic clr_scan;   // scan index to zero
    logic inc_scan;
    logic rd_req;     // read entry at scan slot
    logic store;      // write the received code
    logic rebase;     // add offset to entry at scan slot
    logic set_sync;
    logic [1:0] out_sel; // 0 record, 1 entry, 2 status
    logic [1:0] status;
    logic out_load;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [1:0] op;
    logic below_min;
    logic link;
    logic sync_zero;
    logic synced;
    logic count_zero;
    logic scan_done;  // scan index reached the count
    logic hit;        // registered read code matches
    logic scan_last;  // scan index is the last entry
  } stat_t;

  function automatic logic [47:0] ratios_of(input logic [7:0] proto);
    logic [47:0] r;
    r = 48'h01_03_03_01_1F_01;
    case (proto)
      8'd2:    r = 48'h01_02_02_01_0A_01;
      8'd3:    r = 48'h06_09_0B_04_47_1E;
      8'd4:    r = 48'h01_03_03_01_06_01;
      8'd5:    r = 48'h01_02_02_01_0E_06;
      8'd6:    r = 48'h01_02_02_01_01_17;
      8'd7:    r = 48'h01_06_06_01_3E_02;
      default: r = 48'h01_03_03_01_1F_01;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/core/dshl_stream_if.sv =====
// ----------------------------------------------------------------------------
// dshl_stream_if
// Valid/ready channel carrying one payload beat.
// ----------------------------------------------------------------------------
interface dshl_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/dshl_ctrl.sv =====
// ----------------------------------------------------------------------------
// dshl_ctrl
// Sequencer: search, store, rebase and query read-out.
// ----------------------------------------------------------------------------
module dshl_ctrl
  import dshl_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  state_e state_q, state_d;
  logic   ovalid_q, ovalid_d;
  logic   entry_q, entry_d; // query read-out in progress

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= SIdle;
      ovalid_q <= 1'b0;
      entry_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
      entry_q  <= entry_d;
    end
  end

  assign out_valid_o = ovalid_q;
  assign in_ready_o  = (state_q == SIdle) && !ovalid_q;

  always_comb begin
    state_d  = state_q;
    entry_d  = entry_q;
    cmd_o    = '0;
    ovalid_d = ovalid_q && !out_ready_i;
    unique case (state_q)
      SIdle: begin
        if (in_valid_i && in_ready_o) begin
          cmd_o.load     = 1'b1;
          cmd_o.clr_scan = 1'b1;
          state_d        = SSearch;
          entry_d        = 1'b0;
        end
      end
      // first cycle after capture: decide
      SSearch: begin
        unique case (op_e'(stat_i.op))
          OpCode: begin
            if (stat_i.below_min) state_d = SIdle;
            else if (stat_i.link) begin
              cmd_o.out_sel  = KindRecord;
              cmd_o.out_load = 1'b1;
              ovalid_d       = 1'b1;
              state_d        = SIdle;
            end else if (stat_i.count_zero) state_d = SStore;
            else begin
              cmd_o.rd_req = 1'b1;
              state_d      = SReadWait;
            end
          end
          OpSync: begin
            cmd_o.out_sel  = KindStatus;
            cmd_o.out_load = 1'b1;
            ovalid_d       = 1'b1;
            if (stat_i.sync_zero) begin
              cmd_o.status = StBadTime;
              state_d      = SIdle;
            end else begin
              cmd_o.status = StSynced;
              if (stat_i.synced || stat_i.count_zero) begin
                cmd_o.set_sync = 1'b1;
                state_d        = SIdle;
              end else state_d = SRebase;
            end
          end
          OpQuery: begin
            cmd_o.out_sel  = KindStatus;
            cmd_o.out_load = 1'b1;
            ovalid_d       = 1'b1;
            if (stat_i.count_zero) begin
              cmd_o.status = StNoHistory;
              state_d      = SIdle;
            end else begin
              cmd_o.status = StCount;
              entry_d      = 1'b1;
              state_d      = SOut;
            end
          end
          default: state_d = SIdle;
        endcase
      end
      SReadWait: begin
        // registered code of the scan slot is now valid
        if (stat_i.hit) state_d = SStore;
        else if (stat_i.scan_last) begin
          cmd_o.clr_scan = 1'b1; // scan index back to zero on a miss
          state_d        = SStore;
        end else begin
          cmd_o.inc_scan = 1'b1;
          state_d        = SReadReq;
        end
      end
      SReadReq: begin
        cmd_o.rd_req = 1'b1;
        state_d      = SReadWait;
      end
      SStore: begin
        cmd_o.store = 1'b1;
        state_d     = SIdle;
      end
      SRebase: begin
        cmd_o.rebase   = 1'b1;
        cmd_o.inc_scan = 1'b1;
        if (stat_i.scan_last) begin
          cmd_o.set_sync = 1'b1;
          state_d        = SIdle;
        end
      end
      SOut: begin
        // wait for the output register to drain, then read the next entry or go idle
        if (!ovalid_q || out_ready_i) begin
          if (entry_q && !stat_i.scan_done) begin
            cmd_o.rd_req = 1'b1;
            state_d      = SReadWait;
            entry_d      = 1'b1;
            state_d      = SReadReq;
          end else begin
            state_d = SIdle;
            entry_d = 1'b0;
          end
        end
      end
      default: state_d = SIdle;
    endcase
    // query read-out reuses the read states
    if (entry_q) begin
      if (state_q == SReadReq) begin
        cmd_o.rd_req = 1'b1;
        state_d      = SReadWait;
      end else if (state_q == SReadWait) begin
        cmd_o          = '0;
        cmd_o.out_sel  = KindEntry;
        cmd_o.out_load = 1'b1;
        cmd_o.inc_scan = 1'b1;
        ovalid_d       = 1'b1;
        state_d        = SOut;
      end else if (state_q == SOut) begin
        cmd_o.rd_req = 1'b0;
      end
    end
  end

endmodule

// ===== rtl/core/dshl_datapath.sv =====
// ----------------------------------------------------------------------------
// dshl_datapath
// Item register, entry memory, ring pointers, time offset and result register.
// ----------------------------------------------------------------------------
module dshl_datapath
  import dshl_pkg::*;
#(
  parameter int unsigned HISTORY_DEPTH = HistoryDepthDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  in_item_t            in_i,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  cmd_t                cmd_i,
  output stat_t               stat_o,
  output out_item_t           out_o
);

  localparam int unsigned IdxW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(HISTORY_DEPTH + 1);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(HISTORY_DEPTH - 1);

  typedef struct packed {
    logic [31:0] code;
    logic [6:0]  bits;
    logic [15:0] pulse;
    logic [47:0] ratios;
    logic        inv;
    logic [15:0] rep;
    logic [63:0] ts;
  } entry_t;

  entry_t mem_q [HISTORY_DEPTH];
  entry_t rd_q;

  logic [31:0]     min_code_q;
  logic [15:0]     def_rep_q;
  in_item_t        item_q;
  logic [IdxW-1:0] wr_idx_q;
  logic [CntW-1:0] count_q, scan_q;
  logic [63:0]     offset_q;
  logic            synced_q;
  out_item_t       out_q, out_d;

  logic            full;
  logic [IdxW:0]   slot_sum;
  logic [IdxW-1:0] slot, hit_slot_q;
  logic            hit_q;
  logic [47:0]     ratios;
  logic            inv;
  logic [63:0]     ts, new_off;
  entry_t          wr_e;
  logic [IdxW-1:0] st_slot;
  logic [IdxW-1:0] rb_slot_q;
  logic            rb_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_code_q <= MinCodeReset;
      def_rep_q  <= DefaultRepeatReset;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CfgMinCode) min_code_q <= cfg_data_i;
      else def_rep_q <= cfg_data_i[15:0];
    end
  end

  assign full     = (count_q == CntW'(HISTORY_DEPTH));
  // oldest-first slot: scan offset from the ring start
  assign slot_sum = (full ? {1'b0, wr_idx_q} : '0) + (IdxW + 1)'(scan_q);
  assign slot     = (slot_sum >= (IdxW + 1)'(HISTORY_DEPTH))
                    ? IdxW'(slot_sum - (IdxW + 1)'(HISTORY_DEPTH)) : slot_sum[IdxW-1:0];

  assign ratios  = ratios_of(item_q.protocol_id);
  assign inv     = (item_q.protocol_id == 8'd6);
  assign ts      = synced_q ? (64'(item_q.now_ms) + offset_q) : 64'(item_q.now_ms);
  assign new_off = item_q.sync_time - 64'(item_q.now_ms);
  assign st_slot = hit_q ? hit_slot_q : wr_idx_q;

  always_comb begin
    wr_e        = '0;
    wr_e.code   = item_q.code;
    wr_e.bits   = item_q.bit_length;
    wr_e.pulse  = item_q.pulse_length;
    wr_e.ratios = ratios;
    wr_e.inv    = inv;
    wr_e.rep    = def_rep_q;
    wr_e.ts     = ts;
    if (cmd_i.rebase) begin
      wr_e    = rd_q;
      wr_e.ts = rd_q.ts + new_off;
    end
  end

  // entry memory: one write, one registered read per cycle; rebase reads
  // each slot and writes its timestamp back the cycle after
  always_ff @(posedge clk_i) begin
    rb_slot_q <= slot;
    if (cmd_i.store) mem_q[st_slot] <= wr_e;
    else if (rb_valid_q) mem_q[rb_slot_q].ts <= rd_q.ts + new_off;
    if (cmd_i.rd_req || cmd_i.rebase) rd_q <= mem_q[slot];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) rb_valid_q <= 1'b0;
    else rb_valid_q <= cmd_i.rebase;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) item_q <= in_i;
    if (cmd_i.rd_req) hit_slot_q <= slot;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_idx_q <= '0;
      count_q  <= '0;
      scan_q   <= '0;
      offset_q <= '0;
      synced_q <= 1'b0;
      hit_q    <= 1'b0;
    end else begin
      if (cmd_i.clr_scan) scan_q <= '0;
      else if (cmd_i.inc_scan) scan_q <= scan_q + 1'b1;
      if (cmd_i.load) hit_q <= 1'b0;
      else if (stat_o.hit) hit_q <= 1'b1;
      if (cmd_i.store && !hit_q) begin
        wr_idx_q <= (wr_idx_q == LastIdx) ? '0 : wr_idx_q + 1'b1;
        if (!full) count_q <= count_q + 1'b1;
      end
      if (cmd_i.set_sync) begin
        offset_q <= new_off;
        synced_q <= 1'b1;
      end
    end
  end

  always_comb begin
    out_d = '0;
    unique case (cmd_i.out_sel)
      KindRecord: begin
        out_d.kind          = KindRecord;
        out_d.code_out      = item_q.code;
        out_d.bits_out      = item_q.bit_length;
        out_d.pulse_out     = item_q.pulse_length;
        out_d.timing_ratios = ratios;
        out_d.inverted      = inv;
        out_d.repeat_out    = def_rep_q;
        out_d.timestamp     = ts;
        out_d.last          = 1'b1;
      end
      KindEntry: begin
        out_d.kind          = KindEntry;
        out_d.code_out      = rd_q.code;
        out_d.bits_out      = rd_q.bits;
        out_d.pulse_out     = rd_q.pulse;
        out_d.timing_ratios = rd_q.ratios;
        out_d.inverted      = rd_q.inv;
        out_d.repeat_out    = rd_q.rep;
        out_d.timestamp     = rd_q.ts;
        out_d.last          = (scan_q + 1'b1 == count_q);
      end
      default: begin
        out_d.kind        = KindStatus;
        out_d.status      = cmd_i.status;
        out_d.entry_count = (cmd_i.status == StCount) ? 5'(count_q) : 5'd0;
        out_d.last        = (cmd_i.status != StCount);
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) out_q <= out_d;
  end

  assign out_o = out_q;

  assign stat_o.op         = item_q.op;
  assign stat_o.below_min  = item_q.code < min_code_q;
  assign stat_o.link       = item_q.link_connected;
  assign stat_o.sync_zero  = (item_q.sync_time == 64'd0);
  assign stat_o.synced     = synced_q;
  assign stat_o.count_zero = (count_q == '0);
  assign stat_o.scan_done  = (scan_q == count_q);
  assign stat_o.hit        = (rd_q.code == item_q.code);
  assign stat_o.scan_last  = (scan_q + 1'b1 == count_q);

endmodule

// ===== rtl/core/dedup_signal_history_log.sv =====
// A forwarded record or a status passes the item register, then the result
// register. A logged code holds the input while it is compared with the N
// stored entries, one memory read per compare; the first sync holds it while
// it rebases the N entries; a query reads each entry once the previous has
// left the result register. One item is processed at a time.
// Reset: asynchronous, empties the log and clears the sync state; stored
// entries are not cleared.
// ----------------------------------------------------------------------------
// dedup_signal_history_log
// Deduplicating ring log of received radio codes, top level.
// ----------------------------------------------------------------------------
module dedup_signal_history_log
  import dshl_pkg::*;
#(
  parameter int unsigned HISTORY_DEPTH = HistoryDepthDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  dshl_stream_if.sink         in_if,
  dshl_stream_if.source       out_if
);

  cmd_t  cmd;
  stat_t stat;

  dshl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_ready_o  (in_if.ready),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  dshl_datapath #(.HISTORY_DEPTH(HISTORY_DEPTH)) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_if.data),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .out_o      (out_if.data)
  );

endmodule

// ===== rtl/core/dshl_checker.sv =====
// ----------------------------------------------------------------------------
// dshl_checker
// Port-level checks on the history log, bound to the top level.
// ----------------------------------------------------------------------------
module dshl_checker
  import dshl_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  // no new input while a result beat waits
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> !in_ready) else $error("input taken with result pending");

  a_status_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && out_data.kind == KindStatus) |-> out_data.code_out == '0
    && out_data.timestamp == '0) else $error("status beat carries payload");

  a_count_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && out_data.kind == KindStatus && out_data.status == StCount)
    |-> !out_data.last) else $error("count status marked last");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && !out_ready) |=> out_valid && $stable(out_data))
    else $error("result dropped under stall");

endmodule

bind dedup_signal_history_log dshl_checker u_chk (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (in_if.valid),
  .in_ready  (in_if.ready),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .out_data  (out_if.data)
);

// ===== tb/tb_dedup_signal_history_log.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_dedup_signal_history_log
// Self-checking bench for the history log: a queue-fed driver pushes received
// codes, syncs and queries, a monitor compares each output beat with a local
// prediction of the log, and configuration is rewritten between phases.
// ----------------------------------------------------------------------------
module tb_dedup_signal_history_log;
  import dshl_pkg::*;

  localparam int unsigned Depth    = 30;
  localparam int unsigned CycleMax = 2000000;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  dshl_stream_if #(.T(in_item_t))  in_if ();
  dshl_stream_if #(.T(out_item_t)) out_if ();

  dedup_signal_history_log #(.HISTORY_DEPTH(Depth)) i_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .in_if     (in_if),
    .out_if    (out_if)
  );

  // predicted log contents
  logic [31:0] log_code  [Depth];
  logic [6:0]  log_bits  [Depth];
  logic [15:0] log_pulse [Depth];
  logic [47:0] log_ratio [Depth];
  logic        log_inv   [Depth];
  logic [15:0] log_rep   [Depth];
  logic [63:0] log_time  [Depth];
  int unsigned log_wr, log_cnt;
  logic [63:0] clock_offset;
  logic        clock_synced;
  logic [31:0] min_code;
  logic [15:0] def_repeat;

  in_item_t    pending_items[$];
  out_item_t   expected_beats[$];
  int unsigned mismatches;
  int unsigned cycles;
  bit          quiet;     // no idling in the last part

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic report(input string what);
    $display("MISMATCH at cycle %0d: %s", cycles, what);
    mismatches++;
  endtask

  function automatic logic [47:0] ratio_bytes(input logic [7:0] proto);
    logic [7:0] r[6];
    case (proto)
      8'd2:    r = '{8'd1, 8'd10, 8'd1, 8'd2, 8'd2, 8'd1};
      8'd3:    r = '{8'd30, 8'd71, 8'd4, 8'd11, 8'd9, 8'd6};
      8'd4:    r = '{8'd1, 8'd6, 8'd1, 8'd3, 8'd3, 8'd1};
      8'd5:    r = '{8'd6, 8'd14, 8'd1, 8'd2, 8'd2, 8'd1};
      8'd6:    r = '{8'd23, 8'd1, 8'd1, 8'd2, 8'd2, 8'd1};
      8'd7:    r = '{8'd2, 8'd62, 8'd1, 8'd6, 8'd6, 8'd1};
      default: r = '{8'd1, 8'd31, 8'd1, 8'd3, 8'd3, 8'd1};
    endcase
    return {r[5], r[4], r[3], r[2], r[1], r[0]};
  endfunction

  function automatic int unsigned slot_of(input int unsigned i);
    return ((log_cnt < Depth ? 0 : log_wr) + i) % Depth;
  endfunction

  function automatic out_item_t status_beat(input status_e st, input int unsigned cnt,
                                            input logic lst);
    out_item_t o;
    o = '0;
    o.kind = KindStatus;
    o.status = st;
    o.entry_count = cnt[4:0];
    o.last = lst;
    return o;
  endfunction

  // Updates the predicted log and queues the beats an accepted item causes.
  task automatic predict_log(input in_item_t it);
    out_item_t   o;
    logic [63:0] ts, off;
    int unsigned s;
    bit          hit;
    o = '0;
    hit = 0;
    s = 0;
    case (op_e'(it.op))
      OpCode: begin
        ts = clock_synced ? {32'd0, it.now_ms} + clock_offset : {32'd0, it.now_ms};
        if (it.code >= min_code) begin
          if (it.link_connected) begin
            o.kind = KindRecord;
            o.code_out = it.code;
            o.bits_out = it.bit_length;
            o.pulse_out = it.pulse_length;
            o.timing_ratios = ratio_bytes(it.protocol_id);
            o.inverted = (it.protocol_id == 8'd6);
            o.repeat_out = def_repeat;
            o.timestamp = ts;
            o.last = 1'b1;
            expected_beats.push_back(o);
          end else begin
            for (int unsigned i = 0; i < log_cnt; i++) begin
              if (!hit && log_code[slot_of(i)] == it.code) begin
                hit = 1;
                s = slot_of(i);
              end
            end
            if (!hit) begin
              s = log_wr % Depth;
              log_wr = (s + 1) % Depth;
              if (log_cnt < Depth) log_cnt++;
            end
            log_code[s] = it.code;
            log_bits[s] = it.bit_length;
            log_pulse[s] = it.pulse_length;
            log_ratio[s] = ratio_bytes(it.protocol_id);
            log_inv[s] = (it.protocol_id == 8'd6);
            log_rep[s] = def_repeat;
            log_time[s] = ts;
          end
        end
      end
      OpSync: begin
        if (it.sync_time == 64'd0) begin
          expected_beats.push_back(status_beat(StBadTime, 0, 1'b1));
        end else begin
          off = it.sync_time - {32'd0, it.now_ms};
          if (!clock_synced)
            for (int unsigned i = 0; i < log_cnt; i++) log_time[slot_of(i)] += off;
          clock_offset = off;
          clock_synced = 1'b1;
          expected_beats.push_back(status_beat(StSynced, 0, 1'b1));
        end
      end
      OpQuery: begin
        if (log_cnt == 0) begin
          expected_beats.push_back(status_beat(StNoHistory, 0, 1'b1));
        end else begin
          expected_beats.push_back(status_beat(StCount, log_cnt, 1'b0));
          for (int unsigned i = 0; i < log_cnt; i++) begin
            s = slot_of(i);
            o = '0;
            o.kind = KindEntry;
            o.code_out = log_code[s];
            o.bits_out = log_bits[s];
            o.pulse_out = log_pulse[s];
            o.timing_ratios = log_ratio[s];
            o.inverted = log_inv[s];
            o.repeat_out = log_rep[s];
            o.timestamp = log_time[s];
            o.last = (i + 1 == log_cnt);
            expected_beats.push_back(o);
          end
        end
      end
      default: ;
    endcase
  endtask

  // Driver: idles in bursts, holds valid until the beat is taken.
  int unsigned src_idle;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      in_if.data <= '0;
      src_idle = 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        predict_log(in_if.data);
        void'(pending_items.pop_front());
      end
      if (src_idle > 0) src_idle--;
      else if (!quiet && $urandom_range(0, 9) == 0) src_idle = $urandom_range(1, 11);
      if (pending_items.size() > 0 && src_idle == 0
          && !(in_if.valid && !in_if.ready)) begin
        in_if.valid <= 1'b1;
        in_if.data <= pending_items[0];
      end else if (!(in_if.valid && !in_if.ready)) begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Monitor: compares each output beat with the oldest prediction.
  int unsigned snk_idle;
  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t e, g;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      snk_idle = 0;
    end else begin
      cycles++;
      if (out_if.valid && out_if.ready) begin
        g = out_if.data;
        if (expected_beats.size() == 0) begin
          report($sformatf("unexpected beat %h", g));
        end else begin
          e = expected_beats.pop_front();
          if (g.kind !== e.kind) report($sformatf("kind %0d, want %0d", g.kind, e.kind));
          if (g.status !== e.status)
            report($sformatf("status %0d, want %0d", g.status, e.status));
          if (g.code_out !== e.code_out)
            report($sformatf("code %h, want %h", g.code_out, e.code_out));
          if (g.bits_out !== e.bits_out)
            report($sformatf("bits %0d, want %0d", g.bits_out, e.bits_out));
          if (g.pulse_out !== e.pulse_out)
            report($sformatf("pulse %0d, want %0d", g.pulse_out, e.pulse_out));
          if (g.timing_ratios !== e.timing_ratios)
            report($sformatf("ratios %h, want %h", g.timing_ratios, e.timing_ratios));
          if (g.inverted !== e.inverted)
            report($sformatf("inverted %b, want %b", g.inverted, e.inverted));
          if (g.repeat_out !== e.repeat_out)
            report($sformatf("repeat %0d, want %0d", g.repeat_out, e.repeat_out));
          if (g.timestamp !== e.timestamp)
            report($sformatf("timestamp %h, want %h", g.timestamp, e.timestamp));
          if (g.entry_count !== e.entry_count)
            report($sformatf("count %0d, want %0d", g.entry_count, e.entry_count));
          if (g.last !== e.last) report($sformatf("last %b, want %b", g.last, e.last));
        end
      end
      if (snk_idle > 0) snk_idle--;
      else if (!quiet && $urandom_range(0, 9) == 0) snk_idle = $urandom_range(1, 11);
      out_if.ready <= (snk_idle == 0);
      if (cycles >= CycleMax) begin
        $display("timeout");
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  function automatic in_item_t code_item(input logic [31:0] c, input logic lnk);
    in_item_t it;
    it = '0;
    it.op = OpCode;
    it.code = c;
    it.bit_length = 7'($urandom_range(0, 64));
    it.pulse_length = 16'($urandom);
    it.protocol_id = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 8));
    it.link_connected = lnk;
    it.now_ms = $urandom;
    it.sync_time = {$urandom, $urandom};
    return it;
  endfunction

  function automatic in_item_t op_item(input op_e op, input logic [63:0] st);
    in_item_t it;
    it = code_item($urandom, 1'($urandom_range(0, 1)));
    it.op = op;
    it.sync_time = st;
    return it;
  endfunction

  task automatic drain();
    while (pending_items.size() > 0 || expected_beats.size() > 0) @(posedge clk_i);
    // a logged code leaves nothing to wait for; allow its scan to finish
    repeat (2 * Depth + 10) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [31:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CfgMinCode) min_code = val;
    else def_repeat = val[15:0];
  endtask

  // Random phase: mostly codes from a small pool so duplicates hit the log.
  task automatic random_phase(input int unsigned n, input logic [31:0] pool_base);
    int unsigned r;
    for (int unsigned k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < 60)
        pending_items.push_back(code_item(pool_base + $urandom_range(0, 40),
                                          $urandom_range(0, 4) == 0));
      else if (r < 70)
        pending_items.push_back(code_item($urandom, 1'($urandom_range(0, 1))));
      else if (r < 78)
        pending_items.push_back(op_item(OpSync, ($urandom_range(0, 4) == 0) ? 64'd0
                                                 : {$urandom, $urandom}));
      else if (r < 97) pending_items.push_back(op_item(OpQuery, '0));
      else pending_items.push_back(op_item(OpNone, {$urandom, $urandom}));
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    in_if.valid = 1'b0;
    in_if.data = '0;
    out_if.ready = 1'b0;
    log_wr = 0;
    log_cnt = 0;
    clock_offset = '0;
    clock_synced = 1'b0;
    min_code = MinCodeReset;
    def_repeat = DefaultRepeatReset;
    mismatches = 0;
    cycles = 0;
    quiet = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty query, bad sync, threshold edges, all protocols, unused op
    pending_items.push_back(op_item(OpQuery, '0));
    pending_items.push_back(op_item(OpSync, 64'd0));
    pending_items.push_back(code_item(32'd999, 1'b1));
    pending_items.push_back(code_item(32'd999, 1'b0));
    pending_items.push_back(code_item(32'd1000, 1'b1));
    pending_items.push_back(code_item(32'hFFFF_FFFF, 1'b0));
    for (int unsigned p = 0; p < 9; p++) begin
      in_item_t it;
      it = code_item(32'd2000 + p, p[0]);
      it.protocol_id = (p == 8) ? 8'hFF : p[7:0];
      it.bit_length = (p == 0) ? 7'd64 : 7'd0;
      it.pulse_length = (p == 0) ? 16'hFFFF : 16'd0;
      pending_items.push_back(it);
    end
    pending_items.push_back(code_item(32'd2003, 1'b0)); // logged anew: the earlier 2003 was forwarded, not logged
    pending_items.push_back(op_item(OpQuery, '0));
    pending_items.push_back(op_item(OpNone, '1));
    pending_items.push_back(op_item(OpSync, 64'hFFFF_FFFF_FFFF_FFFF)); // first sync
    pending_items.push_back(op_item(OpSync, 64'd1));
    pending_items.push_back(op_item(OpQuery, '0));
    drain();

    write_reg(CfgMinCode, 32'd0);
    write_reg(CfgDefaultRepeat, 32'h0000_FFFF);
    random_phase(140, 32'd0);
    drain();
    write_reg(CfgMinCode, 32'hFFFF_FFFF);
    write_reg(CfgDefaultRepeat, 32'd0);
    random_phase(40, 32'hFFFF_FFD7);
    drain();
    write_reg(CfgMinCode, 32'd20);
    write_reg(CfgDefaultRepeat, 32'($urandom_range(0, 65535)));
    random_phase(150, 32'd0);
    drain();
    quiet = 1;
    write_reg(CfgMinCode, 32'h8000_0000);
    write_reg(CfgDefaultRepeat, 32'd10);
    random_phase(110, 32'h7FFF_FFF0);
    drain();

    if (mismatches == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule
